@@ src/mves_pkg.sv @@
package mves_pkg;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] channel;
    logic [7:0] key;
    logic [7:0] data_byte;
    logic [9:0] table_address;
  } in_item_t;

  typedef struct packed {
    logic [7:0] midi_byte;
    logic       last;
  } out_item_t;

  // Input command codes
  localparam logic [2:0] CMD_NOTE_ON     = 3'd0;
  localparam logic [2:0] CMD_NOTE_OFF    = 3'd1;
  localparam logic [2:0] CMD_CONTROLLER  = 3'd2;
  localparam logic [2:0] CMD_PITCH_BEND  = 3'd3;
  localparam logic [2:0] CMD_SET_MASTER  = 3'd4;
  localparam logic [2:0] CMD_TABLE_WRITE = 3'd5;

  // Classified operation passed from front to back
  typedef enum logic [3:0] {
    OP_NOTE_ON, OP_NOTE_OFF, OP_VOLUME, OP_PAN, OP_SUSTAIN, OP_ALL_OFF,
    OP_BEND, OP_MASTER, OP_WR_DRUM, OP_WR_CURVE, OP_WR_XPOSE, OP_WR_OFFSET,
    OP_WR_ROW, OP_WR_DISABLE
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [3:0] chan;
    logic [7:0] key;
    logic [7:0] data;
    logic [9:0] idx;
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_DRUM, ST_FOLD, ST_NOTE, ST_CURVE, ST_MSEL,
    ST_VMUL, ST_VDIV, ST_VFIN, ST_EMIT
  } back_state_t;

  // MIDI bytes and controller numbers
  localparam logic [7:0] STATUS_NOTE  = 8'h90;
  localparam logic [7:0] STATUS_CTRL  = 8'hb0;
  localparam logic [7:0] STATUS_BEND  = 8'he0;
  localparam logic [7:0] CC_VOLUME    = 8'h07;
  localparam logic [7:0] CC_PAN       = 8'h0a;
  localparam logic [7:0] CC_SUSTAIN   = 8'h40;
  localparam logic [7:0] CC_ALL_OFF   = 8'h7b;
  localparam logic [7:0] NO_VALUE     = 8'hff;
  localparam logic [7:0] FOLD_UP      = 8'h0c;
  localparam logic [7:0] FOLD_DOWN    = 8'hf4;
  localparam logic [7:0] MAX_DATA     = 8'h7f;
  localparam logic [3:0] DRUM_CHANNEL = 4'd9;
  localparam logic [4:0] MASTER_DIV   = 5'd15;
  localparam logic [7:0] MASTER_INIT  = 8'h0c;

endpackage

@@ src/mves_front.sv @@
module mves_front #(
  parameter int CURVE_ROWS = 4
) (
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mves_pkg::in_item_t in_item,
  input  logic               q_full,
  output logic               q_push,
  output mves_pkg::op_t      q_op
);
  import mves_pkg::*;

  localparam int XposeBase = 128 + CURVE_ROWS * 128;
  localparam int OffsBase  = XposeBase + 16;
  localparam int RowBase   = OffsBase + 16;
  localparam int DisBase   = RowBase + 16;
  localparam int TableEnd  = DisBase + 16;

  logic keep;
  int   addr;

  assign in_stall = q_full;
  assign addr     = int'(in_item.table_address);

  // Decode command into an operation; items that never have an effect are dropped here
  always_comb begin
    keep      = 1'b1;
    q_op.kind = OP_NOTE_ON;
    q_op.chan = in_item.channel;
    q_op.key  = in_item.key;
    q_op.data = in_item.data_byte;
    q_op.idx  = in_item.table_address;
    unique case (in_item.command)
      CMD_NOTE_ON:  q_op.kind = OP_NOTE_ON;
      CMD_NOTE_OFF: q_op.kind = OP_NOTE_OFF;
      CMD_CONTROLLER: begin
        q_op.data = in_item.data_byte & MAX_DATA;
        priority if (in_item.key == CC_VOLUME)  q_op.kind = OP_VOLUME;
        else if (in_item.key == CC_PAN)         q_op.kind = OP_PAN;
        else if (in_item.key == CC_SUSTAIN)     q_op.kind = OP_SUSTAIN;
        else if (in_item.key == CC_ALL_OFF)     q_op.kind = OP_ALL_OFF;
        else                                    keep = 1'b0;
      end
      CMD_PITCH_BEND: q_op.kind = OP_BEND;
      CMD_SET_MASTER: begin
        q_op.kind = OP_MASTER;
        keep      = (in_item.data_byte != NO_VALUE);
      end
      CMD_TABLE_WRITE: begin
        priority if (addr < 128) begin
          q_op.kind = OP_WR_DRUM;
        end else if (addr < XposeBase) begin
          q_op.kind = OP_WR_CURVE;
          q_op.idx  = 10'(addr - 128);
        end else if (addr < OffsBase) begin
          q_op.kind = OP_WR_XPOSE;
          q_op.idx  = 10'(addr - XposeBase);
        end else if (addr < RowBase) begin
          q_op.kind = OP_WR_OFFSET;
          q_op.idx  = 10'(addr - OffsBase);
        end else if (addr < DisBase) begin
          q_op.kind = OP_WR_ROW;
          q_op.idx  = 10'(addr - RowBase);
        end else if (addr < TableEnd) begin
          q_op.kind = OP_WR_DISABLE;
          q_op.idx  = 10'(addr - DisBase);
        end else begin
          keep = 1'b0;
        end
      end
      default: keep = 1'b0;
    endcase
  end

  assign q_push = in_valid && !q_full && keep && !rst;

endmodule

@@ src/mves_queue.sv @@
module mves_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mves_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output mves_pkg::op_t head_op
);
  import mves_pkg::*;

  op_t        entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign full       = (count == 3'd4);
  assign head_valid = (count != 3'd0);
  assign head_op    = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_op;
  end

endmodule

@@ src/mves_back.sv @@
module mves_back #(
  parameter int CURVE_ROWS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_enable,
  input  logic                cfg_write_data,
  input  logic                head_valid,
  input  mves_pkg::op_t       head_op,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output mves_pkg::out_item_t out_item
);
  import mves_pkg::*;

  localparam int CW = $clog2(CURVE_ROWS * 128);
  // ceil(2^19 / 15); exact quotient for products below 2^15
  localparam logic [15:0] RECIP15 = 16'h8889;

  back_state_t state, state_next;
  op_t         op;

  // Tables
  logic [7:0] drum_mem  [128];
  logic [7:0] curve_mem [CURVE_ROWS * 128];
  logic [7:0] drum_rd;
  logic [7:0] curve_rd;
  logic [7:0] transpose_amount [16];
  logic [7:0] volume_offset    [16];
  logic [1:0] curve_row        [16];
  logic       channel_off      [16];

  // Channel state with defined reset
  logic [7:0] stored_volume  [16];
  logic [7:0] stored_pan     [16];
  logic [7:0] stored_sustain [16];
  logic [7:0] bend_low       [16];
  logic [7:0] bend_high      [16];
  logic [15:0] sounding;
  logic [7:0]  master_level;
  logic        master_enable;

  // Work registers
  logic [7:0]  note;
  logic [7:0]  fold_step;
  logic [8:0]  mask;
  logic [3:0]  vch;
  logic [7:0]  vval;
  logic [15:0] dq;
  logic        prod_nz;
  logic [7:0]  b0, b1, b2;
  logic [1:0]  cnt;

  logic        load;
  logic [CW-1:0] curve_addr;
  logic [1:0]  row_mod;
  logic [7:0]  vsum, vsat, voff;
  logic [31:0] recip;
  logic [3:0]  msel_ch;
  logic [8:0]  mask_init;
  logic [7:0]  qsat;

  assign pop  = (state == ST_IDLE) && head_valid;
  assign load = (state == ST_EXEC) ? 1'b0 : (state == ST_EMIT) && (!out_valid || !out_stall);

  // Curve row folded onto the rows that exist
  always_comb begin
    unique case (curve_row[op.chan])
      2'd0:    row_mod = 2'(0 % CURVE_ROWS);
      2'd1:    row_mod = 2'(1 % CURVE_ROWS);
      2'd2:    row_mod = 2'(2 % CURVE_ROWS);
      default: row_mod = 2'(3 % CURVE_ROWS);
    endcase
  end

  assign curve_addr = (CW'(row_mod) << 7) | CW'(op.data[6:0]);

  // Volume: offset with clamp
  assign voff = volume_offset[vch];
  assign vsum = vval + voff;
  assign vsat = vsum[7] ? (voff[7] ? 8'd1 : MAX_DATA) : vsum;

  // Divide by 15 through a reciprocal multiply
  assign recip = dq * RECIP15;

  // Quotient saturation and minimum of one for a nonzero product
  always_comb begin
    qsat = dq[7:0];
    if (dq > 16'(MAX_DATA)) qsat = MAX_DATA;
    else if (dq == 16'd0 && prod_nz) qsat = 8'd1;
  end

  // Lowest pending resend channel, and the initial resend set
  always_comb begin
    msel_ch = 4'd0;
    for (int i = 8; i >= 0; i--) begin
      if (mask[i]) msel_ch = 4'(i + 1);
    end
    for (int i = 0; i < 9; i++) begin
      mask_init[i] = (stored_volume[i + 1] != NO_VALUE);
    end
  end

  // Table memories, registered read
  always_ff @(posedge clk) begin
    drum_rd  <= drum_mem[op.key[6:0]];
    curve_rd <= curve_mem[curve_addr];
    if (state == ST_EXEC && op.kind == OP_WR_DRUM) drum_mem[op.idx[6:0]] <= op.data;
    if (state == ST_EXEC && op.kind == OP_WR_CURVE) curve_mem[CW'(op.idx)] <= op.data;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (head_valid) state_next = ST_EXEC;
      ST_EXEC: begin
        unique case (op.kind)
          OP_NOTE_ON, OP_NOTE_OFF: begin
            if (op.chan == DRUM_CHANNEL)       state_next = ST_DRUM;
            else if (channel_off[op.chan])     state_next = ST_IDLE;
            else                               state_next = ST_FOLD;
          end
          OP_VOLUME: state_next = master_enable ? ST_VMUL : ST_IDLE;
          OP_PAN: state_next = (stored_pan[op.chan] != op.data) ? ST_EMIT : ST_IDLE;
          OP_SUSTAIN:
            state_next = (stored_sustain[op.chan] != op.data) ? ST_EMIT : ST_IDLE;
          OP_ALL_OFF: state_next = sounding[op.chan] ? ST_EMIT : ST_IDLE;
          OP_BEND: begin
            if (bend_low[op.chan] != op.data || bend_high[op.chan] != op.key)
              state_next = ST_EMIT;
            else
              state_next = ST_IDLE;
          end
          OP_MASTER: state_next = master_enable ? ST_MSEL : ST_IDLE;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_DRUM: begin
        if (drum_rd == NO_VALUE)           state_next = ST_IDLE;
        else if (op.kind == OP_NOTE_ON)    state_next = ST_CURVE;
        else                               state_next = ST_EMIT;
      end
      ST_FOLD: if (!note[7]) state_next = ST_NOTE;
      ST_NOTE:  state_next = (op.kind == OP_NOTE_ON) ? ST_CURVE : ST_EMIT;
      ST_CURVE: state_next = ST_EMIT;
      ST_MSEL:  state_next = (mask == 9'd0) ? ST_IDLE : ST_VMUL;
      ST_VMUL:  state_next = ST_VDIV;
      ST_VDIV:  state_next = ST_VFIN;
      ST_VFIN:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (load && cnt == 2'd2) state_next = (mask != 9'd0) ? ST_MSEL : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Configuration and state with reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      master_enable <= 1'b1;
      master_level  <= MASTER_INIT;
      sounding      <= '0;
      for (int i = 0; i < 16; i++) begin
        stored_volume[i]  <= NO_VALUE;
        stored_pan[i]     <= NO_VALUE;
        stored_sustain[i] <= NO_VALUE;
        bend_low[i]       <= NO_VALUE;
        bend_high[i]      <= NO_VALUE;
      end
    end else begin
      if (cfg_write_enable) master_enable <= cfg_write_data;
      if (state == ST_EXEC) begin
        unique case (op.kind)
          OP_VOLUME:  stored_volume[op.chan]  <= op.data;
          OP_PAN:     stored_pan[op.chan]     <= op.data;
          OP_SUSTAIN: stored_sustain[op.chan] <= op.data;
          OP_ALL_OFF: sounding[op.chan]       <= 1'b0;
          OP_BEND: begin
            bend_low[op.chan]  <= op.data;
            bend_high[op.chan] <= op.key;
          end
          OP_MASTER: master_level <= op.data;
          default: ;
        endcase
      end
      if (state == ST_NOTE && op.kind == OP_NOTE_ON) sounding[op.chan] <= 1'b1;
      if (state == ST_DRUM && drum_rd != NO_VALUE && op.kind == OP_NOTE_ON)
        sounding[op.chan] <= 1'b1;
    end
  end

  // Per-channel tables, undefined until written
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      unique case (op.kind)
        OP_WR_XPOSE:   transpose_amount[op.idx[3:0]] <= op.data;
        OP_WR_OFFSET:  volume_offset[op.idx[3:0]]    <= op.data;
        OP_WR_ROW:     curve_row[op.idx[3:0]]        <= op.data[1:0];
        OP_WR_DISABLE: channel_off[op.idx[3:0]]      <= (op.data == NO_VALUE);
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
      cnt  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (head_valid) op <= head_op;
        ST_EXEC: begin
          cnt  <= 2'd0;
          mask <= (op.kind == OP_MASTER) ? mask_init : 9'd0;
          note <= op.key + transpose_amount[op.chan];
          fold_step <= transpose_amount[op.chan][7] ? FOLD_UP : FOLD_DOWN;
          vch  <= op.chan;
          vval <= op.data;
          b0   <= ((op.kind == OP_BEND) ? STATUS_BEND : STATUS_CTRL) | {4'd0, op.chan};
          b1   <= op.key;
          b2   <= op.data;
        end
        ST_DRUM: begin
          note <= drum_rd;
          b0   <= STATUS_NOTE | {4'd0, op.chan};
          b1   <= drum_rd;
          b2   <= 8'd0;
        end
        ST_FOLD: if (note[7]) note <= note + fold_step;
        ST_NOTE: begin
          b0 <= STATUS_NOTE | {4'd0, op.chan};
          b1 <= note;
          b2 <= 8'd0;
        end
        ST_CURVE: b2 <= curve_rd;
        ST_MSEL: begin
          if (mask != 9'd0) begin
            vch  <= msel_ch;
            vval <= stored_volume[msel_ch];
            mask[msel_ch - 4'd1] <= 1'b0;
          end
        end
        ST_VMUL: dq <= 16'(master_level * vsat);
        ST_VDIV: begin
          dq      <= 16'(recip[31:19]);
          prod_nz <= (dq != 16'd0);
        end
        ST_VFIN: begin
          b0  <= STATUS_CTRL | {4'd0, vch};
          b1  <= CC_VOLUME;
          b2  <= qsat;
          cnt <= 2'd0;
        end
        ST_EMIT: if (load) cnt <= (cnt == 2'd2) ? 2'd0 : cnt + 2'd1;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unique case (cnt)
        2'd0:    out_item.midi_byte <= b0;
        2'd1:    out_item.midi_byte <= b1;
        default: out_item.midi_byte <= b2;
      endcase
      out_item.last <= (cnt == 2'd2) && (mask == 9'd0);
    end
  end

endmodule

@@ src/midi_voice_event_shaper.sv @@
// MIDI voice event shaper.
// Input channel: in_valid / in_stall with one in_item_t per transfer
// (command, channel, key, data_byte, table_address). Output channel:
// out_valid / out_stall with one out_item_t per transfer, a MIDI byte
// plus last, set on the final byte caused by one input item.
// Config: cfg_write_enable / cfg_write_data write master_enable at once.
// A front stage decodes each item and drops those that never have an effect; a
// four-entry queue feeds the back sequencer, which owns all tables.
// Pan, sustain, all-off and bend messages go from EXEC straight to EMIT;
// notes pass DRUM, or FOLD (again per octave fold step) and NOTE, then
// CURVE for a note on; volume passes VMUL, VDIV and VFIN. Items are
// handled one at a time; a master write resends up to nine volume messages.
// Within a message bytes leave at one per cycle while the receiver does
// not stall. Reset clears the queue, the sequencer and the per-channel
// stored values; lookup tables hold nothing until written. A stall holds
// the output register; the sequencer waits and the queue absorbs up to
// four items.
module midi_voice_event_shaper #(
  parameter int CURVE_ROWS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mves_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output mves_pkg::out_item_t out_item,
  input  logic                cfg_write_enable,
  input  logic                cfg_write_data
);
  import mves_pkg::*;

  logic q_full, q_push, q_pop, q_head_valid;
  op_t  q_op, q_head;

  mves_front #(.CURVE_ROWS(CURVE_ROWS)) u_front (
    .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .q_full(q_full), .q_push(q_push), .q_op(q_op)
  );

  mves_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_op(q_op), .full(q_full),
    .pop(q_pop), .head_valid(q_head_valid), .head_op(q_head)
  );

  mves_back #(.CURVE_ROWS(CURVE_ROWS)) u_back (
    .clk(clk), .rst(rst), .cfg_write_enable(cfg_write_enable),
    .cfg_write_data(cfg_write_data), .head_valid(q_head_valid),
    .head_op(q_head), .pop(q_pop), .out_valid(out_valid),
    .out_stall(out_stall), .out_item(out_item)
  );

endmodule

@@ verif/tb_midi_voice_event_shaper.sv @@
`timescale 1ns / 100ps

module tb_midi_voice_event_shaper;
  import mves_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES = 300;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic      cfg_write_enable = 1'b0;
  logic      cfg_write_data = 1'b0;

  midi_voice_event_shaper u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_item          (in_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_item         (out_item),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data)
  );

  always #2 clk = ~clk;

  // Shadow of the block's tables and per-channel state
  logic [7:0] drum_tbl [128];
  logic [7:0] curve_tbl [512];
  logic [7:0] xpose_tbl [16];
  logic [7:0] voff_tbl [16];
  logic [1:0] row_tbl [16];
  bit         mute_tbl [16];
  logic [7:0] vol_st [16];
  logic [7:0] pan_st [16];
  logic [7:0] sus_st [16];
  logic [7:0] bend_lo_st [16];
  logic [7:0] bend_hi_st [16];
  bit         sounding_st [16];
  logic [7:0] master_lvl;
  bit         master_on;

  out_item_t midi_expect_q [$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        hold_cnt = 0;
  bit        hold_req = 1'b0;
  bit        calm = 1'b0;

  task automatic push_msg(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    midi_expect_q.push_back('{midi_byte: a, last: 1'b0});
    midi_expect_q.push_back('{midi_byte: b, last: 1'b0});
    midi_expect_q.push_back('{midi_byte: c, last: 1'b0});
  endtask

  task automatic send_volume(input int ch, input logic [7:0] v);
    logic [7:0]  off;
    logic [7:0]  s;
    logic [15:0] prod;
    logic [15:0] q;
    logic [15:0] r;
    off = voff_tbl[ch];
    vol_st[ch] = v;
    if (master_on) begin
      s = v + off;
      if (s >= 8'h80) s = (off >= 8'h80) ? 8'd1 : 8'h7f;
      prod = master_lvl * s;
      q = prod / 15;
      r = prod % 15;
      if (q > 16'h7f) q = 16'h7f;
      if (q == 0 && r != 0) q = 1;
      push_msg(STATUS_CTRL | 8'(ch), CC_VOLUME, q[7:0]);
    end
  endtask

  // Resolve note; returns 0 when the event is dropped
  function automatic bit map_note(input int ch, input logic [7:0] key, output logic [7:0] note);
    logic [7:0] t;
    logic [7:0] step;
    note = '0;
    if (ch == DRUM_CHANNEL) begin
      note = drum_tbl[key[6:0]];
      return note != NO_VALUE;
    end
    if (mute_tbl[ch]) return 0;
    t = xpose_tbl[ch];
    step = (t >= 8'h80) ? FOLD_UP : FOLD_DOWN;
    note = key + t;
    while (note >= 8'h80) note = note + step;
    return 1;
  endfunction

  // Expected MIDI bytes for one accepted event
  task automatic shape_event(input in_item_t it);
    int         n0;
    int         ch;
    logic [7:0] note;
    logic [7:0] val;
    logic [9:0] a;
    n0 = midi_expect_q.size();
    ch = it.channel;
    val = {1'b0, it.data_byte[6:0]};
    a = it.table_address;
    case (it.command)
      CMD_NOTE_ON: if (map_note(ch, it.key, note)) begin
        sounding_st[ch] = 1;
        push_msg(STATUS_NOTE | 8'(ch), note,
                 curve_tbl[{row_tbl[ch], it.data_byte[6:0]}]);
      end
      CMD_NOTE_OFF: if (map_note(ch, it.key, note))
        push_msg(STATUS_NOTE | 8'(ch), note, 8'h00);
      CMD_CONTROLLER: begin
        if (it.key == CC_VOLUME) send_volume(ch, val);
        else if (it.key == CC_PAN) begin
          if (pan_st[ch] != val) begin
            pan_st[ch] = val;
            push_msg(STATUS_CTRL | 8'(ch), it.key, val);
          end
        end else if (it.key == CC_SUSTAIN) begin
          if (sus_st[ch] != val) begin
            sus_st[ch] = val;
            push_msg(STATUS_CTRL | 8'(ch), it.key, val);
          end
        end else if (it.key == CC_ALL_OFF) begin
          if (sounding_st[ch]) begin
            sounding_st[ch] = 0;
            push_msg(STATUS_CTRL | 8'(ch), it.key, val);
          end
        end
      end
      CMD_PITCH_BEND: if (bend_lo_st[ch] != it.data_byte || bend_hi_st[ch] != it.key) begin
        bend_lo_st[ch] = it.data_byte;
        bend_hi_st[ch] = it.key;
        push_msg(STATUS_BEND | 8'(ch), it.key, it.data_byte);
      end
      CMD_SET_MASTER: if (it.data_byte != NO_VALUE) begin
        master_lvl = it.data_byte;
        if (master_on)
          for (int i = 1; i < 10; i++)
            if (vol_st[i] != NO_VALUE) send_volume(i, vol_st[i]);
      end
      CMD_TABLE_WRITE: begin
        if (a < 128) drum_tbl[a] = it.data_byte;
        else if (a < 640) curve_tbl[a - 128] = it.data_byte;
        else if (a < 656) xpose_tbl[a - 640] = it.data_byte;
        else if (a < 672) voff_tbl[a - 656] = it.data_byte;
        else if (a < 688) row_tbl[a - 672] = it.data_byte[1:0];
        else if (a < 704) mute_tbl[a - 688] = (it.data_byte == 8'hff);
      end
      default: ;
    endcase
    if (midi_expect_q.size() > n0) midi_expect_q[midi_expect_q.size() - 1].last = 1'b1;
  endtask

  // One input transfer; valid stays high afterwards until the next gap
  task automatic send_item(input in_item_t it);
    if (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    shape_event(it);
    @(negedge clk);
  endtask

  task automatic send(input logic [2:0] cmd, input logic [3:0] ch, input logic [7:0] key,
                      input logic [7:0] dat, input logic [9:0] addr);
    send_item('{command: cmd, channel: ch, key: key, data_byte: dat, table_address: addr});
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (midi_expect_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_master_enable(input bit en);
    cfg_write_enable <= 1'b1;
    cfg_write_data <= en;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    master_on = en;
  endtask

  // Note events stay on the loaded drum keys and velocities
  task automatic random_item();
    logic [2:0] cmd;
    logic [7:0] key;
    logic [7:0] dat;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 25) cmd = CMD_NOTE_ON;
    else if (pick < 40) cmd = CMD_NOTE_OFF;
    else if (pick < 70) cmd = CMD_CONTROLLER;
    else if (pick < 80) cmd = CMD_PITCH_BEND;
    else if (pick < 87) cmd = CMD_SET_MASTER;
    else if (pick < 97) cmd = CMD_TABLE_WRITE;
    else cmd = 3'($urandom_range(6, 7));
    key = 8'($urandom);
    if (cmd == CMD_CONTROLLER) begin
      case ($urandom_range(4))
        0: key = CC_VOLUME;
        1: key = CC_PAN;
        2: key = CC_SUSTAIN;
        3: key = CC_ALL_OFF;
        default: ;
      endcase
    end
    // small data values make repeats (no-change cases) likely
    dat = ($urandom_range(1) != 0) ? 8'($urandom) : 8'($urandom_range(3));
    if (cmd == CMD_NOTE_ON || cmd == CMD_NOTE_OFF) begin
      key = {key[7], 3'd0, key[3:0]};
      dat = {dat[7], 4'd0, dat[2:0]};
    end
    send(cmd, 4'($urandom), key, dat, 10'($urandom));
  endtask

  // Every table entry that the bench's lookups can reach is written first
  task automatic test_load_tables();
    for (int i = 0; i < 16; i++)
      send(CMD_TABLE_WRITE, 4'($urandom), 8'($urandom),
           (i == 5) ? NO_VALUE : 8'($urandom), 10'(i));
    for (int r = 0; r < 4; r++)
      for (int v = 0; v < 8; v++)
        send(CMD_TABLE_WRITE, 4'($urandom), 8'($urandom), 8'($urandom),
             10'(128 + r * 128 + v));
    for (int i = 0; i < 16; i++) begin
      send(CMD_TABLE_WRITE, 4'(i), 8'($urandom), 8'($urandom), 10'(640 + i));
      send(CMD_TABLE_WRITE, 4'(i), 8'($urandom), 8'($urandom), 10'(656 + i));
      send(CMD_TABLE_WRITE, 4'(i), 8'($urandom), 8'($urandom), 10'(672 + i));
      send(CMD_TABLE_WRITE, 4'(i), 8'($urandom), (i == 3) ? 8'hff : 8'h00, 10'(688 + i));
    end
  endtask

  task automatic test_directed();
    send(CMD_NOTE_ON, 4'd0, 8'd0, 8'd0, 10'd0);
    send(CMD_NOTE_ON, 4'd15, 8'hff, 8'h87, 10'h3ff);
    send(CMD_NOTE_ON, 4'd9, 8'd5, 8'd64, 10'd0);        // drum map drop
    send(CMD_NOTE_OFF, 4'd9, 8'd133, 8'd0, 10'd0);      // drop via key modulo
    send(CMD_NOTE_ON, 4'd9, 8'd140, 8'd6, 10'd0);
    send(CMD_NOTE_ON, 4'd3, 8'd60, 8'd90, 10'd0);       // disabled channel
    send(CMD_NOTE_OFF, 4'd0, 8'd0, 8'd33, 10'd0);
    send(CMD_CONTROLLER, 4'd1, CC_VOLUME, 8'd0, 10'd0);
    send(CMD_CONTROLLER, 4'd2, CC_VOLUME, 8'hff, 10'd0);
    send(CMD_CONTROLLER, 4'd2, CC_PAN, 8'd64, 10'd0);
    send(CMD_CONTROLLER, 4'd2, CC_PAN, 8'hc0, 10'd0);   // same after mask
    send(CMD_CONTROLLER, 4'd4, CC_SUSTAIN, 8'd127, 10'd0);
    send(CMD_CONTROLLER, 4'd0, CC_ALL_OFF, 8'd0, 10'd0);
    send(CMD_CONTROLLER, 4'd0, CC_ALL_OFF, 8'd0, 10'd0); // not sounding
    send(CMD_CONTROLLER, 4'd5, 8'd1, 8'd10, 10'd0);      // unknown controller
    send(CMD_PITCH_BEND, 4'd6, 8'h40, 8'h00, 10'd0);
    send(CMD_PITCH_BEND, 4'd6, 8'h40, 8'h00, 10'd0);     // unchanged bend
    send(CMD_SET_MASTER, 4'd0, 8'd0, NO_VALUE, 10'd0);   // read-only request
    send(CMD_SET_MASTER, 4'd0, 8'd0, 8'd0, 10'd0);
    send(CMD_SET_MASTER, 4'd0, 8'd0, 8'd200, 10'd0);     // saturating
    send(CMD_SET_MASTER, 4'd0, 8'd0, 8'd15, 10'd0);
    send(3'd6, 4'd1, 8'd1, 8'd1, 10'd0);
    send(3'd7, 4'd1, 8'd1, 8'd1, 10'd0);
    send(CMD_TABLE_WRITE, 4'd0, 8'd0, 8'd9, 10'd1000);   // past the end
  endtask

  task automatic test_master_disabled();
    wait_idle();
    set_master_enable(1'b0);
    send(CMD_CONTROLLER, 4'd7, CC_VOLUME, 8'd100, 10'd0);
    send(CMD_SET_MASTER, 4'd0, 8'd0, 8'd9, 10'd0);
    repeat (20) random_item();
    wait_idle();
    set_master_enable(1'b1);
  endtask

  // Receiver holds off while the sender keeps offering notes
  task automatic test_backpressure();
    wait_idle();
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++)
      send(CMD_NOTE_ON, 4'($urandom_range(15)), 8'($urandom_range(15)),
           8'($urandom_range(7)), 10'd0);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      calm = (i >= 20 && i < 50);
      random_item();
    end
    calm = 1'b0;
  endtask

  // Reset values of the shadow state
  initial begin
    for (int i = 0; i < 16; i++) begin
      vol_st[i] = NO_VALUE;
      pan_st[i] = NO_VALUE;
      sus_st[i] = NO_VALUE;
      bend_lo_st[i] = NO_VALUE;
      bend_hi_st[i] = NO_VALUE;
      sounding_st[i] = 0;
    end
    master_lvl = MASTER_INIT;
    master_on = 1'b1;
  end

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_master_enable(1'b1);
    test_load_tables();
    test_directed();
    test_random(60);
    test_master_disabled();
    test_backpressure();
    test_random(20);
    wait_idle();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Receiver stall pattern; the long hold is counted here
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 13);
    end
  end

  // Output check and watchdog
  always @(posedge clk) begin
    out_item_t exp_b;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (midi_expect_q.size() == 0) begin
          $display("%0t: unexpected transfer byte %h last %b", $time,
                   out_item.midi_byte, out_item.last);
          mismatches = mismatches + 1;
        end else begin
          exp_b = midi_expect_q.pop_front();
          if (exp_b.midi_byte !== out_item.midi_byte) begin
            $display("%0t: midi_byte expected %h actual %h", $time,
                     exp_b.midi_byte, out_item.midi_byte);
            mismatches = mismatches + 1;
          end
          if (exp_b.last !== out_item.last) begin
            $display("%0t: last expected %b actual %b", $time, exp_b.last, out_item.last);
            mismatches = mismatches + 1;
          end
        end
      end
    end
  end

endmodule

@@ midi_voice_event_shaper.f @@
src/mves_pkg.sv
src/mves_front.sv
src/mves_queue.sv
src/mves_back.sv
src/midi_voice_event_shaper.sv
verif/tb_midi_voice_event_shaper.sv
